/* rtl/fkpt_pkg.sv */
`default_nettype none

package fkpt_pkg;

    localparam int ENTRIES    = 64;
    localparam int PAGE_BYTES = 4096;
    localparam int ADDR_W     = 32;
    localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
    localparam int TAG_W      = ADDR_W - PAGE_SHIFT;
    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int FC_W       = 7;
    localparam int WB_W       = 7;
    localparam int TOT_W      = 32;
    localparam logic [FC_W-1:0] LIMIT_RESET = FC_W'(8);

    typedef enum logic [0:0] {
        OP_REF   = 1'b0,
        OP_FLUSH = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [ADDR_W-1:0]   address;
        logic                write_ref;
    } t_in_item;

    typedef struct packed {
        logic                hit;
        logic                fault;
        logic                flushed;
        logic [WB_W-1:0]     flush_writes;
        logic [TOT_W-1:0]    read_total;
        logic [TOT_W-1:0]    write_total;
    } t_out_item;

    // lookup result of the tag store for the page in the input register
    typedef struct packed {
        logic                hit;
        logic                hit_clean;
        logic                full;
        logic [CNT_W-1:0]    dirty_cnt;
    } t_tag_look;

    // table update applied when the item moves to the result register
    typedef struct packed {
        logic                flush;
        logic                insert;
        logic                dirty_hit;
        logic                write_ref;
    } t_tag_upd;

endpackage

`default_nettype wire

/* rtl/flush_after_k_faults_page_table_top.sv */
// Input transfers go to the input register, results to the result register.
// Throughput: one item per cycle unless the output stalls; the 64-entry
// parallel tag match and the running dirty count never stall an item.
// Reset (synchronous, active low): table empty, fault count and totals zero,
// fault limit 8. Tag contents are not cleared; no clearing pass is needed.
`default_nettype none

module flush_after_k_faults_page_table_top
    import fkpt_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_wr_en,
    input  wire logic [FC_W-1:0] i_cfg_wr_data,
    input  wire logic            i_valid,
    output logic                 o_stall,
    input  wire t_in_item        i_data,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output t_out_item            o_data
);

    logic             r_s1_vld;
    t_in_item         r_s1;
    logic             r_out_vld;
    t_out_item        r_out;
    logic [FC_W-1:0]  r_limit;
    logic [FC_W-1:0]  r_fc;
    logic [TOT_W-1:0] r_read_count;
    logic [TOT_W-1:0] r_write_count;

    logic             n_s1_vld;
    logic             n_out_vld;
    t_out_item        n_out;
    logic [FC_W-1:0]  n_fc;
    logic [TOT_W-1:0] n_read_count;
    logic [TOT_W-1:0] n_write_count;

    logic             in_xfer;
    logic             out_free;
    logic             adv;
    logic             is_ref;
    logic             miss;
    logic             limit_flush;
    logic             full_flush;
    logic             flushed;
    logic [FC_W-1:0]  fc_inc;
    logic [CNT_W-1:0] writes;
    t_tag_look        look;
    t_tag_upd         upd;

    assign out_free = !r_out_vld || !i_stall;
    assign adv      = r_s1_vld && out_free;
    assign o_stall  = r_s1_vld && !out_free;
    assign in_xfer  = i_valid && !o_stall;
    assign n_s1_vld = in_xfer || (r_s1_vld && !adv);
    assign n_out_vld = out_free ? adv : 1'b1;

    fkpt_tag_store u_tags (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_page   (r_s1.address[ADDR_W-1:PAGE_SHIFT]),
        .i_upd_en (adv),
        .i_upd    (upd),
        .o_look   (look)
    );

    always_comb begin
        is_ref      = (r_s1.opcode == OP_REF);
        miss        = is_ref && !look.hit;
        fc_inc      = r_fc + FC_W'(1);
        limit_flush = miss && (fc_inc == r_limit);
        // a limit above the table size: a miss on a full table flushes too
        full_flush  = miss && !limit_flush && look.full;
        flushed     = !is_ref || limit_flush || full_flush;
        writes      = flushed ? look.dirty_cnt : '0;

        upd.flush     = flushed;
        upd.insert    = miss;
        upd.dirty_hit = is_ref && look.hit && r_s1.write_ref;
        upd.write_ref = r_s1.write_ref;

        if (flushed) begin
            n_fc = '0;
        end else if (miss) begin
            n_fc = fc_inc;
        end else begin
            n_fc = r_fc;
        end
        n_read_count  = r_read_count + TOT_W'(miss);
        n_write_count = r_write_count + TOT_W'(writes);

        n_out.hit          = is_ref && look.hit;
        n_out.fault        = miss;
        n_out.flushed      = flushed;
        n_out.flush_writes = WB_W'(writes);
        n_out.read_total   = n_read_count;
        n_out.write_total  = n_write_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
            r_limit       <= LIMIT_RESET;
            r_fc          <= '0;
            r_read_count  <= '0;
            r_write_count <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_out_vld <= n_out_vld;
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            if (adv) begin
                r_fc          <= n_fc;
                r_read_count  <= n_read_count;
                r_write_count <= n_write_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1 <= i_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    a_hit_xor_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out.hit && r_out.fault))
        else $error("hit and fault both set");

    a_writes_need_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out.flush_writes != '0) |-> r_out.flushed)
        else $error("write-back without flush");

    a_read_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> (r_out.read_total == $past(r_read_count) + TOT_W'(r_out.fault)))
        else $error("read total out of step with faults");

    a_flush_clears_fc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && flushed) |=> (r_fc == '0))
        else $error("fault count not cleared by flush");

endmodule

`default_nettype wire

/* rtl/fkpt_tag_store.sv */
`default_nettype none

module fkpt_tag_store
    import fkpt_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [TAG_W-1:0] i_page,
    input  wire logic             i_upd_en,
    input  wire t_tag_upd         i_upd,
    output t_tag_look             o_look
);

    logic [TAG_W-1:0]   r_tag [ENTRIES];
    logic [ENTRIES-1:0] r_dirty;
    logic [CNT_W-1:0]   r_fill;
    logic [CNT_W-1:0]   r_dcnt;

    logic [ENTRIES-1:0] n_dirty;
    logic [CNT_W-1:0]   n_fill;
    logic [CNT_W-1:0]   n_dcnt;

    logic [ENTRIES-1:0] match;
    logic [IDX_W-1:0]   slot;

    // entries fill in order and are only ever removed all at once,
    // so the valid entries are exactly those below the fill count
    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            match[i] = (CNT_W'(i) < r_fill) && (r_tag[i] == i_page);
        end
    end

    always_comb begin
        o_look.hit       = |match;
        o_look.hit_clean = |(match & ~r_dirty);
        o_look.full      = (r_fill == CNT_W'(ENTRIES));
        o_look.dirty_cnt = r_dcnt;
    end

    assign slot = i_upd.flush ? '0 : r_fill[IDX_W-1:0];

    always_comb begin
        n_dirty = i_upd.flush ? '0 : r_dirty;
        n_fill  = i_upd.flush ? '0 : r_fill;
        n_dcnt  = i_upd.flush ? '0 : r_dcnt;
        if (i_upd.dirty_hit) begin
            n_dirty = n_dirty | match;
            n_dcnt  = n_dcnt + CNT_W'(o_look.hit_clean);
        end
        if (i_upd.insert) begin
            n_dirty[slot] = i_upd.write_ref;
            n_fill        = CNT_W'(slot) + CNT_W'(1);
            n_dcnt        = n_dcnt + CNT_W'(i_upd.write_ref);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= '0;
            r_fill  <= '0;
            r_dcnt  <= '0;
        end else if (i_upd_en) begin
            r_dirty <= n_dirty;
            r_fill  <= n_fill;
            r_dcnt  <= n_dcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_upd_en && i_upd.insert) begin
            r_tag[slot] <= i_page;
        end
    end

endmodule

`default_nettype wire
